### hdl/sparse_transpose_scatter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse transpose scatter checker
// Concurrent property wrappers with a common clock and reset qualifier.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRANSPOSE_SCATTER_DEFINES_SVH
`define SPARSE_TRANSPOSE_SCATTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define STS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types, codes and default sizes shared by the sparse transpose scatter.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int DEF_MAX_DIM      = 4096;
    localparam int DEF_MAX_NONZEROS = 1048576;

    localparam int IDX_W   = 12;
    localparam int LOAD_W  = 21;
    localparam int POS_W   = 20;
    localparam int VALUE_W = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    // Action codes carried by an input transaction
    localparam logic [1:0] ACT_LOAD_POS  = 2'd0;
    localparam logic [1:0] ACT_LOAD_PERM = 2'd1;
    localparam logic [1:0] ACT_NONZERO   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SYMMETRIC_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_UPPER      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_PERMUTATION = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_KIND      = 2'd3;

    // Value kinds; the unused code behaves as complex
    localparam logic [1:0] KIND_PATTERN = 2'd0;
    localparam logic [1:0] KIND_REAL    = 2'd1;
    localparam logic [1:0] KIND_COMPLEX = 2'd2;

    localparam logic [VALUE_W-1:0] SIGN_MASK = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]         action;
        logic [IDX_W-1:0]   row_index;
        logic [IDX_W-1:0]   col_index;
        logic [LOAD_W-1:0]  load_value;
        logic [VALUE_W-1:0] value_real;
        logic [VALUE_W-1:0] value_imag;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   dest_position;
        logic [IDX_W-1:0]   dest_index;
        logic [VALUE_W-1:0] out_real;
        logic [VALUE_W-1:0] out_imag;
    } out_item_t;

endpackage

### hdl/sparse_transpose_scatter.sv
// ----------------------------------------------------------------------------
// sparse_transpose_scatter
// Scatter stage of a compressed-column sparse transpose.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries load and nonzero
// transactions. A load writes the row position table or the inverse
// permutation table; the block stays idle. A nonzero reads the position of
// its destination row, emits it and writes back the post-incremented value.
// Output channel (out_valid/out_ready/out_data) gives one result for each
// kept nonzero; dropped entries give none.
// A nonzero is accepted, then the position RAM is read and written back;
// with permutation both inverse permutation entries come first, one after
// the other from the single read port; the output register loads with
// the write-back. Configuration writes via cfg_we/cfg_index/cfg_data:
// only while idle, a user rule that the block does not enforce.
// Reset clears the mode registers (value kind to real) and the control
// state; table contents are undefined until loaded. While the receiver
// stalls, a new transaction is still accepted; the write-back stage then
// holds until the output register is taken.
// ----------------------------------------------------------------------------
module sparse_transpose_scatter
    import sts_pkg::*;
#(
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_DIM);
    localparam int PW = $clog2(MAX_NONZEROS + 1);
    localparam logic [31:0] DIM_L   = 32'(MAX_DIM);
    localparam logic [31:0] NZ_L    = 32'(MAX_NONZEROS);
    localparam logic [31:0] NZ_M1_L = NZ_L - 32'd1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PERM_I = 2'd1;
    localparam logic [1:0] ST_PERM_J = 2'd2;
    localparam logic [1:0] ST_POS    = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             sym_reg, upper_reg, perm_reg;
    logic [1:0]       kind_reg;
    in_item_t         item_reg;
    logic [IDX_W-1:0] pi_reg, pi_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             conj_reg, conj_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             accept;
    logic             r_ok, c_ok, tri_drop;
    logic [31:0]      r_ext, c_ext, lv_ext, lv_clamp;
    logic [IDX_W-1:0] pj, sel_row, sel_idx;
    logic             sel_conj;
    logic [31:0]      sel_ext, row_ext, cur_ext, emit_ext, inc_ext;
    logic             load_out;

    logic             pos_we, pos_re;
    logic [AW-1:0]    pos_waddr, pos_raddr;
    logic [PW-1:0]    pos_wdata, pos_rdata;
    logic             perm_we, perm_re;
    logic [AW-1:0]    perm_raddr;
    logic [IDX_W-1:0] perm_rdata;

    sts_ram #(
        .WIDTH(PW),
        .DEPTH(MAX_DIM)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    sts_ram #(
        .WIDTH(IDX_W),
        .DEPTH(MAX_DIM)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (r_ext[AW-1:0]),
        .wdata (in_data.load_value[IDX_W-1:0]),
        .re    (perm_re),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign r_ext    = 32'(in_data.row_index);
    assign c_ext    = 32'(in_data.col_index);
    assign r_ok     = r_ext < DIM_L;
    assign c_ok     = c_ext < DIM_L;
    assign tri_drop = upper_reg ? (in_data.row_index > in_data.col_index)
                                : (in_data.row_index < in_data.col_index);
    assign lv_ext   = 32'(in_data.load_value);
    assign lv_clamp = (lv_ext > NZ_L) ? NZ_L : lv_ext;

    // Pick the row in the kept triangle once both permuted indices are known
    assign pj       = perm_rdata;
    assign sel_conj = upper_reg ? (pi_reg < pj) : (pi_reg > pj);
    assign sel_row  = sel_conj ? pi_reg : pj;
    assign sel_idx  = sel_conj ? pj : pi_reg;
    assign sel_ext  = 32'(sel_row);
    assign row_ext  = 32'(row_reg);

    // Saturating position update
    assign cur_ext  = 32'(pos_rdata);
    assign emit_ext = (cur_ext > NZ_M1_L) ? NZ_M1_L : cur_ext;
    assign inc_ext  = (cur_ext < NZ_L) ? (cur_ext + 32'd1) : cur_ext;

    function automatic logic [AW-1:0] c_ext_reg_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] ext;
        ext = 32'(idx);
        return ext[AW-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        pi_next    = pi_reg;
        row_next   = row_reg;
        idx_next   = idx_reg;
        conj_next  = conj_reg;
        pos_we     = 1'b0;
        pos_waddr  = r_ext[AW-1:0];
        pos_wdata  = lv_clamp[PW-1:0];
        pos_re     = 1'b0;
        pos_raddr  = r_ext[AW-1:0];
        perm_we    = 1'b0;
        perm_re    = 1'b0;
        perm_raddr = r_ext[AW-1:0];
        load_out   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.action)
                        ACT_LOAD_POS:
                        begin
                            pos_we = r_ok;
                        end
                        ACT_LOAD_PERM:
                        begin
                            perm_we = r_ok;
                        end
                        ACT_NONZERO:
                        begin
                            if (!sym_reg || (!tri_drop && !perm_reg))
                            begin
                                if (r_ok)
                                begin
                                    pos_re     = 1'b1;
                                    row_next   = in_data.row_index;
                                    idx_next   = in_data.col_index;
                                    conj_next  = 1'b1;
                                    state_next = ST_POS;
                                end
                            end
                            else if (!tri_drop && r_ok && c_ok)
                            begin
                                perm_re    = 1'b1;
                                state_next = ST_PERM_I;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PERM_I:
            begin
                pi_next    = perm_rdata;
                perm_re    = 1'b1;
                perm_raddr = c_ext_reg_addr(item_reg.col_index);
                state_next = ST_PERM_J;
            end
            ST_PERM_J:
            begin
                row_next  = sel_row;
                idx_next  = sel_idx;
                conj_next = sel_conj;
                if (sel_ext < DIM_L)
                begin
                    pos_re     = 1'b1;
                    pos_raddr  = sel_ext[AW-1:0];
                    state_next = ST_POS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POS:
            begin
                // hold the write-back until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    pos_we     = 1'b1;
                    pos_waddr  = row_ext[AW-1:0];
                    pos_wdata  = inc_ext[PW-1:0];
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next               = out_data_reg;
        out_data_next.dest_position = emit_ext[POS_W-1:0];
        out_data_next.dest_index    = idx_reg;
        case (kind_reg)
            KIND_PATTERN:
            begin
                out_data_next.out_real = '0;
                out_data_next.out_imag = '0;
            end
            KIND_REAL:
            begin
                out_data_next.out_real = item_reg.value_real;
                out_data_next.out_imag = '0;
            end
            default:
            begin
                out_data_next.out_real = item_reg.value_real;
                out_data_next.out_imag = conj_reg ? (item_reg.value_imag ^ SIGN_MASK)
                                                  : item_reg.value_imag;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sym_reg       <= 1'b0;
            upper_reg     <= 1'b0;
            perm_reg      <= 1'b0;
            kind_reg      <= KIND_REAL;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SYMMETRIC_MODE:  sym_reg   <= cfg_data[0];
                    REG_KEEP_UPPER:      upper_reg <= cfg_data[0];
                    REG_USE_PERMUTATION: perm_reg  <= cfg_data[0];
                    REG_VALUE_KIND:      kind_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        pi_reg   <= pi_next;
        row_reg  <= row_next;
        idx_reg  <= idx_next;
        conj_reg <= conj_next;
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hdl/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data while no read is issued
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the sparse transpose scatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparse_transpose_scatter_defines.svh"

module sts_checker
    import sts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled result holds
    `STS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

    // Table loads finish in the accept cycle
    `STS_ASSERT_NEXT(a_load_single, clk, rst_n, in_valid && in_ready && in_data.action != ACT_NONZERO, in_ready, "load transaction left the block busy")

    // Only a nonzero makes the block busy
    `STS_ASSERT_SAME(a_busy_cause, clk, rst_n, $fell(in_ready), $past(in_valid && in_data.action == ACT_NONZERO), "block busy without a nonzero")

    // A fresh result traces back to an accepted nonzero, direct or permuted
    `STS_ASSERT_SAME(a_out_origin, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_data.action == ACT_NONZERO, 2) || $past(in_valid && in_ready && in_data.action == ACT_NONZERO, 4), "result without a nonzero")

endmodule

bind sparse_transpose_scatter sts_checker u_sts_checker (.*);
